@@ hw/rtl/key_autorepeat_accel_defines.svh @@
// Assertion macros for the key auto-repeat block checkers
`ifndef KEY_AUTOREPEAT_ACCEL_DEFINES_SVH
`define KEY_AUTOREPEAT_ACCEL_DEFINES_SVH

// clocked check, off while in reset
`define KAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, also active across reset
`define KAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/kar_pkg.sv @@
// Shared types and constants for the key auto-repeat block
package kar_pkg;

    localparam int DELTA_BITS_DEF = 16;
    localparam int VAL_W          = 16;
    localparam int KIND_W         = 3;
    localparam int CFG_IDX_W      = 3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam logic [KIND_W-1:0] KEY_OTHER = 3'd0;
    localparam logic [KIND_W-1:0] KEY_UP    = 3'd1;
    localparam logic [KIND_W-1:0] KEY_DOWN  = 3'd2;
    localparam logic [KIND_W-1:0] KEY_LEFT  = 3'd3;
    localparam logic [KIND_W-1:0] KEY_RIGHT = 3'd4;
    localparam logic [KIND_W-1:0] KEY_ENTER = 3'd5;
    localparam logic [KIND_W-1:0] KEY_BACK  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP    = 3'd3;

    localparam logic [VAL_W-1:0] RST_INITIAL_DELAY = 16'd500;
    localparam logic [VAL_W-1:0] RST_REPEAT_IVL    = 16'd150;
    localparam logic [VAL_W-1:0] RST_MIN_IVL       = 16'd30;
    localparam logic [VAL_W-1:0] RST_ACCEL_STEP    = 16'd10;

    typedef struct packed {
        logic [VAL_W-1:0] initial_delay;
        logic [VAL_W-1:0] repeat_ivl;
        logic [VAL_W-1:0] min_ivl;
        logic [VAL_W-1:0] accel_step;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  param;
        logic              from_repeat;
    } t_key_item;

    typedef struct packed {
        logic [KIND_W-1:0] key;
        logic [VAL_W-1:0]  param;
    } t_result;

endpackage

@@ hw/rtl/kar_cfg_regs.sv @@
// Configuration register file for the key auto-repeat block
module kar_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [kar_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [kar_pkg::VAL_W-1:0]     i_data,
    output kar_pkg::t_cfg                 o_cfg
);

    kar_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay <= kar_pkg::RST_INITIAL_DELAY;
            r_cfg.repeat_ivl    <= kar_pkg::RST_REPEAT_IVL;
            r_cfg.min_ivl       <= kar_pkg::RST_MIN_IVL;
            r_cfg.accel_step    <= kar_pkg::RST_ACCEL_STEP;
        end else if (i_wr) begin
            case (i_index)
                kar_pkg::CFG_INITIAL_DELAY: r_cfg.initial_delay <= i_data;
                kar_pkg::CFG_REPEAT_IVL:    r_cfg.repeat_ivl    <= i_data;
                kar_pkg::CFG_MIN_IVL:       r_cfg.min_ivl       <= i_data;
                kar_pkg::CFG_ACCEL_STEP:    r_cfg.accel_step    <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/kar_core.sv @@
// Repeat state and single-pass tick/key update logic
module kar_core #(
    parameter int DELTA_BITS = kar_pkg::DELTA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  kar_pkg::t_key_item    i_item,
    input  logic [DELTA_BITS-1:0] i_delta,
    input  kar_pkg::t_cfg         i_cfg,
    output logic                  o_fire,
    output kar_pkg::t_result      o_result
);

    localparam int SUM_W = ((DELTA_BITS > kar_pkg::VAL_W) ? DELTA_BITS : kar_pkg::VAL_W) + 1;

    logic                          r_armed, n_armed;
    logic [kar_pkg::KIND_W-1:0]    r_key, n_key;
    logic [kar_pkg::VAL_W-1:0]     r_param, n_param;
    logic [kar_pkg::VAL_W-1:0]     r_elapsed, n_elapsed;
    logic [kar_pkg::VAL_W-1:0]     r_ivl, n_ivl;
    logic                          r_once, n_once;

    logic [SUM_W-1:0]              sum;
    logic [kar_pkg::VAL_W:0]       floor_sum;
    logic [kar_pkg::VAL_W-1:0]     accel_ivl;
    logic                          is_tick;

    assign is_tick   = (i_item.op == kar_pkg::OP_TICK);
    assign sum       = SUM_W'(r_elapsed) + SUM_W'(i_delta);
    assign o_fire    = is_tick && r_armed && (sum >= SUM_W'(r_ivl));
    assign floor_sum = {1'b0, i_cfg.min_ivl} + {1'b0, i_cfg.accel_step};

    // shrink by one step, clamped at the floor; at or below floor stays put
    always_comb begin
        accel_ivl = r_ivl;
        if (r_ivl > i_cfg.min_ivl) begin
            if ({1'b0, r_ivl} >= floor_sum) begin
                accel_ivl = r_ivl - i_cfg.accel_step;
            end else begin
                accel_ivl = i_cfg.min_ivl;
            end
        end
    end

    always_comb begin
        n_armed   = r_armed;
        n_key     = r_key;
        n_param   = r_param;
        n_elapsed = r_elapsed;
        n_ivl     = r_ivl;
        n_once    = r_once;
        if (!is_tick) begin
            if (!i_item.from_repeat) begin
                if (i_item.kind inside {kar_pkg::KEY_UP, kar_pkg::KEY_DOWN,
                                        kar_pkg::KEY_LEFT, kar_pkg::KEY_RIGHT}) begin
                    n_armed   = 1'b1;
                    n_key     = i_item.kind;
                    n_param   = i_item.param;
                    n_elapsed = '0;
                    n_ivl     = i_cfg.initial_delay;
                    n_once    = 1'b0;
                end else if (i_item.kind inside {kar_pkg::KEY_ENTER, kar_pkg::KEY_BACK}) begin
                    n_armed = 1'b0;
                    n_key   = kar_pkg::KEY_OTHER;
                end
            end
        end else if (r_armed) begin
            if (o_fire) begin
                n_elapsed = '0;
                n_once    = 1'b1;
                n_ivl     = r_once ? accel_ivl : i_cfg.repeat_ivl;
            end else begin
                n_elapsed = sum[kar_pkg::VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_key     <= kar_pkg::KEY_OTHER;
            r_elapsed <= '0;
            r_ivl     <= '0;
            r_once    <= 1'b0;
        end else if (i_go) begin
            r_armed   <= n_armed;
            r_key     <= n_key;
            r_elapsed <= n_elapsed;
            r_ivl     <= n_ivl;
            r_once    <= n_once;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_param <= n_param;
        end
    end

    assign o_result.key   = r_key;
    assign o_result.param = r_param;

endmodule

@@ hw/rtl/key_autorepeat_accel.sv @@
// Key auto-repeat generator with interval acceleration, top level
//
// Input channel (valid/stall): one beat is a tick (op 0, tick_ms) or a key
// event (op 1, key_kind, key_param, from_repeat). A direction press arms the
// repeater, enter/back disarm it, ticks advance elapsed time.
// Output channel (valid/stall): one beat per fired repeat, carrying the held
// direction and its parameter. A tick fires at most one repeat.
// Config channel (valid/ready, always ready): index 0..3 selects initial
// delay, repeat interval, minimum interval, acceleration step; other indexes
// are dropped.
// A beat is registered on acceptance and processed from the input register
// once go is set; a firing tick then loads the output register (o_out_valid).
// Throughput: one beat per cycle unless stalled; the state update is one add,
// one compare and the interval clamp between the input register and the state
// registers. A stalled output holds its beat; beats that fire nothing keep
// flowing, and the input stalls only when a firing tick meets a full, stalled
// output. Reset (synchronous, active low) disarms, empties both registers and
// loads the default config values.
module key_autorepeat_accel #(
    parameter int DELTA_BITS = kar_pkg::DELTA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [kar_pkg::KIND_W-1:0]    i_key_kind,
    input  logic [kar_pkg::VAL_W-1:0]     i_key_param,
    input  logic                          i_from_repeat,
    input  logic [DELTA_BITS-1:0]         i_tick_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kar_pkg::KIND_W-1:0]    o_repeat_key,
    output logic [kar_pkg::VAL_W-1:0]     o_repeat_param,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kar_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kar_pkg::VAL_W-1:0]     i_cfg_data
);

    kar_pkg::t_cfg      cfg;
    kar_pkg::t_key_item r_item;
    logic [DELTA_BITS-1:0] r_delta;
    logic               r_in_vld;
    logic               r_out_vld;
    kar_pkg::t_result   r_out;
    kar_pkg::t_result   result;
    logic               fire;
    logic               go;
    logic               accept;

    assign o_cfg_ready = 1'b1;

    kar_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    kar_core #(.DELTA_BITS(DELTA_BITS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (r_item),
        .i_delta  (r_delta),
        .i_cfg    (cfg),
        .o_fire   (fire),
        .o_result (result)
    );

    assign go         = r_in_vld && (!fire || !r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !go;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op          <= i_op;
            r_item.kind        <= i_key_kind;
            r_item.param       <= i_key_param;
            r_item.from_repeat <= i_from_repeat;
            r_delta            <= i_tick_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (go && fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_repeat_key   = r_out.key;
    assign o_repeat_param = r_out.param;

endmodule

@@ hw/rtl/kar_checker.sv @@
// Port-level assertion checker for the key auto-repeat block, with its bind
`include "key_autorepeat_accel_defines.svh"

module kar_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [kar_pkg::KIND_W-1:0] o_repeat_key,
    input logic [kar_pkg::VAL_W-1:0]  o_repeat_param
);

    logic out_dir_ok;

    assign out_dir_ok = o_repeat_key inside {kar_pkg::KEY_UP, kar_pkg::KEY_DOWN,
                                             kar_pkg::KEY_LEFT, kar_pkg::KEY_RIGHT};

    `KAR_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_repeat_key) && $stable(o_repeat_param)),
        "stalled output beat changed")
    `KAR_ASSERT(a_in_stall_cause, i_clk, i_rst_n,
        o_in_stall |-> (o_out_valid && i_out_stall),
        "input stalled without a blocked output")
    `KAR_ASSERT(a_key_dir, i_clk, i_rst_n, o_out_valid |-> out_dir_ok,
        "repeat beat without a direction key")
    `KAR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall),
        "output not empty after reset")

endmodule

bind key_autorepeat_accel kar_checker u_kar_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_repeat_key   (o_repeat_key),
    .o_repeat_param (o_repeat_param)
);
